/* hdl/aabb_pkg.sv */
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants of the box push-out tracker
// Field widths, action codes, item and result records, position clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_pkg;

	localparam int POS_W  = 24;  // signed Q16.8 coordinate
	localparam int SIZE_W = 20;  // unsigned Q12.8 size
	localparam int DT_W   = 16;  // unsigned Q0.16 seconds
	localparam int ACT_W  = 2;
	localparam int SUM_W  = POS_W + 2;  // room for a coordinate sum before clamping

	localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD    = 2'd0,
		ACT_MOVE    = 2'd1,
		ACT_COLLIDE = 2'd2
	} action_t;

	typedef struct packed {
		logic [SIZE_W-1:0] box_width;
		logic [SIZE_W-1:0] box_height;
	} cfg_t;

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic signed [POS_W-1:0]  load_x;
		logic signed [POS_W-1:0]  load_y;
		logic signed [POS_W-1:0]  rect_left;
		logic signed [POS_W-1:0]  rect_top;
		logic [SIZE_W-1:0]        rect_width;
		logic [SIZE_W-1:0]        rect_height;
		logic [DT_W-1:0]          delta_time;
		logic signed [POS_W-1:0]  vel_x;
		logic signed [POS_W-1:0]  vel_y;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic             overlapped;
	} step_res_t;

	// clamp a widened coordinate to the signed coordinate range
	function automatic logic [POS_W-1:0] sat_pos(input logic [SUM_W-1:0] v);
		logic [POS_W-1:0] r;
		if ((v[SUM_W-1:POS_W-1] == '0) || (v[SUM_W-1:POS_W-1] == '1)) begin
			r = v[POS_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = POS_MIN;
		end else begin
			r = POS_MAX;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/aabb_step.sv */
// ----------------------------------------------------------------------------
// aabb_step: next box position for one item
// Load, move by delta_time * velocity with rounding, or push out of an
// obstacle along the axis of smaller penetration. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_step (
	input  aabb_pkg::cfg_t                cfg,
	input  aabb_pkg::item_t               item,
	input  logic [aabb_pkg::POS_W-1:0]    centre_x,
	input  logic [aabb_pkg::POS_W-1:0]    centre_y,
	output aabb_pkg::step_res_t           res
);

	localparam int POS_W  = aabb_pkg::POS_W;
	localparam int SIZE_W = aabb_pkg::SIZE_W;
	localparam int DT_W   = aabb_pkg::DT_W;
	localparam int SUM_W  = aabb_pkg::SUM_W;
	localparam int PROD_W = DT_W + 1 + POS_W;
	localparam int DLT_W  = PROD_W - DT_W;
	localparam int DIF_W  = POS_W + 3;
	localparam int PEN_W  = SIZE_W + 2;
	localparam int HALF_W = SIZE_W + 1;

	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (DT_W - 1);

	// move
	logic signed [PROD_W-1:0] prod_x, prod_y;
	logic signed [PROD_W-1:0] rnd_x, rnd_y;
	logic [SUM_W-1:0]         mv_sum_x, mv_sum_y;

	// collide, doubled units
	logic [SUM_W-1:0]   cx2, cy2;
	logic [DIF_W-1:0]   dif_x, dif_y;
	logic [DIF_W-1:0]   dx, dy;
	logic [DIF_W-1:0]   sum_x, sum_y;
	logic [DIF_W-1:0]   pen_x, pen_y;
	logic [PEN_W-1:0]   pen_x1, pen_y1;
	logic [HALF_W-1:0]  half_x, half_y;
	logic               hit, push_x_axis, pos_dir_x, pos_dir_y;
	logic [SUM_W-1:0]   col_sum_x, col_sum_y;

	always_comb begin
		prod_x   = PROD_W'($signed({1'b0, item.delta_time})) * PROD_W'(item.vel_x);
		prod_y   = PROD_W'($signed({1'b0, item.delta_time})) * PROD_W'(item.vel_y);
		rnd_x    = prod_x + ROUND_HALF;
		rnd_y    = prod_y + ROUND_HALF;
		mv_sum_x = {{2{centre_x[POS_W-1]}}, centre_x}
			+ {rnd_x[PROD_W-1], rnd_x[PROD_W-1:DT_W]};
		mv_sum_y = {{2{centre_y[POS_W-1]}}, centre_y}
			+ {rnd_y[PROD_W-1], rnd_y[PROD_W-1:DT_W]};
	end

	always_comb begin
		cx2   = {item.rect_left[POS_W-1], item.rect_left, 1'b0}
			+ {{(SUM_W-SIZE_W){1'b0}}, item.rect_width};
		cy2   = {item.rect_top[POS_W-1], item.rect_top, 1'b0}
			+ {{(SUM_W-SIZE_W){1'b0}}, item.rect_height};
		dif_x = {{2{centre_x[POS_W-1]}}, centre_x, 1'b0} - {cx2[SUM_W-1], cx2};
		dif_y = {{2{centre_y[POS_W-1]}}, centre_y, 1'b0} - {cy2[SUM_W-1], cy2};
		dx    = dif_x[DIF_W-1] ? (~dif_x + DIF_W'(1)) : dif_x;
		dy    = dif_y[DIF_W-1] ? (~dif_y + DIF_W'(1)) : dif_y;
		sum_x = DIF_W'(cfg.box_width) + DIF_W'(item.rect_width);
		sum_y = DIF_W'(cfg.box_height) + DIF_W'(item.rect_height);
		hit   = (dx < sum_x) && (dy < sum_y);
		pen_x = sum_x - dx;
		pen_y = sum_y - dy;
		// halve rounding up; penetration is below 2^(SIZE_W+1) when overlapping
		pen_x1 = pen_x[PEN_W-1:0] + PEN_W'(1);
		pen_y1 = pen_y[PEN_W-1:0] + PEN_W'(1);
		half_x = pen_x1[PEN_W-1:1];
		half_y = pen_y1[PEN_W-1:1];
		push_x_axis = pen_x < pen_y;
		pos_dir_x   = !dif_x[DIF_W-1] && (dif_x != '0);
		pos_dir_y   = !dif_y[DIF_W-1] && (dif_y != '0);
		col_sum_x = pos_dir_x
			? ({{2{centre_x[POS_W-1]}}, centre_x} + SUM_W'(half_x))
			: ({{2{centre_x[POS_W-1]}}, centre_x} - SUM_W'(half_x));
		col_sum_y = pos_dir_y
			? ({{2{centre_y[POS_W-1]}}, centre_y} + SUM_W'(half_y))
			: ({{2{centre_y[POS_W-1]}}, centre_y} - SUM_W'(half_y));
	end

	always_comb begin
		res.pos_x      = centre_x;
		res.pos_y      = centre_y;
		res.overlapped = 1'b0;
		case (item.action)
			aabb_pkg::ACT_LOAD: begin
				res.pos_x = item.load_x;
				res.pos_y = item.load_y;
			end
			aabb_pkg::ACT_MOVE: begin
				res.pos_x = aabb_pkg::sat_pos(mv_sum_x);
				res.pos_y = aabb_pkg::sat_pos(mv_sum_y);
			end
			aabb_pkg::ACT_COLLIDE: begin
				if (hit) begin
					res.overlapped = 1'b1;
					if (push_x_axis) begin
						res.pos_x = aabb_pkg::sat_pos(col_sum_x);
					end else begin
						res.pos_y = aabb_pkg::sat_pos(col_sum_y);
					end
				end
			end
			default: begin
				res.overlapped = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/aabb_push_out_tracker.sv */
// ----------------------------------------------------------------------------
// aabb_push_out_tracker: box centre tracker with obstacle push-out
// Keeps a box centre, loads it, moves it by velocity and pushes it out of
// obstacle rectangles; one result transfer per input transfer.
// ----------------------------------------------------------------------------
// usage
//   box_width and box_height are written over the APB port (byte addresses 0
//   and 4); write them only while no transfer is in flight.
//   each input transfer carries an action and all of its fields; each gives
//   exactly one output transfer with the new centre and the overlapped flag.
//   an accepted item sits in the input register while the step logic (one
//   17x24 multiply per axis, or adds and compares) computes the new centre;
//   centre and result register load together when the item leaves the input
//   register, and out_valid rises with the result register.
//   one item per cycle is taken unless the receiver stalls; the centre register
//   feeds the next item directly, so back-to-back items chain without a bubble.
//   when the receiver stalls, the result register holds and the input
//   register fills; in_stall rises only once both are occupied.
//   reset clears the centre, the size registers and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_push_out_tracker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [2:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [aabb_pkg::ACT_W-1:0]           action,
	input  logic signed [aabb_pkg::POS_W-1:0]    load_x,
	input  logic signed [aabb_pkg::POS_W-1:0]    load_y,
	input  logic signed [aabb_pkg::POS_W-1:0]    rect_left,
	input  logic signed [aabb_pkg::POS_W-1:0]    rect_top,
	input  logic [aabb_pkg::SIZE_W-1:0]          rect_width,
	input  logic [aabb_pkg::SIZE_W-1:0]          rect_height,
	input  logic [aabb_pkg::DT_W-1:0]            delta_time,
	input  logic signed [aabb_pkg::POS_W-1:0]    vel_x,
	input  logic signed [aabb_pkg::POS_W-1:0]    vel_y,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [aabb_pkg::POS_W-1:0]    pos_x,
	output logic signed [aabb_pkg::POS_W-1:0]    pos_y,
	output logic                                 overlapped
);

	localparam int POS_W  = aabb_pkg::POS_W;
	localparam int SIZE_W = aabb_pkg::SIZE_W;

	aabb_pkg::cfg_t      cfg_q;
	aabb_pkg::item_t     item_s1;
	logic                valid_s1;
	aabb_pkg::step_res_t step_res;
	logic [POS_W-1:0]    centre_x_q, centre_y_q;
	aabb_pkg::step_res_t res_q;
	logic                out_valid_q;
	logic                cfg_wr, in_take, adv_s1;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				cfg_q.box_height <= pwdata[SIZE_W-1:0];
			end else begin
				cfg_q.box_width <= pwdata[SIZE_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2]) begin
			prdata[SIZE_W-1:0] = cfg_q.box_height;
		end else begin
			prdata[SIZE_W-1:0] = cfg_q.box_width;
		end
	end

	// handshake: input register moves on when the result register is free or drained
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.action      <= action;
			item_s1.load_x      <= load_x;
			item_s1.load_y      <= load_y;
			item_s1.rect_left   <= rect_left;
			item_s1.rect_top    <= rect_top;
			item_s1.rect_width  <= rect_width;
			item_s1.rect_height <= rect_height;
			item_s1.delta_time  <= delta_time;
			item_s1.vel_x       <= vel_x;
			item_s1.vel_y       <= vel_y;
		end
	end

	aabb_step u_step (
		.cfg      (cfg_q),
		.item     (item_s1),
		.centre_x (centre_x_q),
		.centre_y (centre_y_q),
		.res      (step_res)
	);

	// tracked centre
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= '0;
			centre_y_q <= '0;
		end else if (adv_s1) begin
			centre_x_q <= step_res.pos_x;
			centre_y_q <= step_res.pos_y;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= step_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign pos_x      = res_q.pos_x;
	assign pos_y      = res_q.pos_y;
	assign overlapped = res_q.overlapped;

endmodule

`default_nettype wire

/* sim/tb_aabb_push_out_tracker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aabb_push_out_tracker: self-checking bench of the box push-out tracker
// Walks a short table of directed steps, then runs random phases under
// several hitbox sizes. Each step is predicted on acceptance and every result
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_aabb_push_out_tracker;

	localparam int ACT_W  = aabb_pkg::ACT_W;
	localparam int POS_W  = aabb_pkg::POS_W;
	localparam int SIZE_W = aabb_pkg::SIZE_W;
	localparam int DT_W   = aabb_pkg::DT_W;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int REG_BOX_W = 0;
	localparam int REG_BOX_H = 1;
	localparam longint COORD_MAX = 64'sd8388607;
	localparam longint COORD_MIN = -64'sd8388608;
	localparam logic [SIZE_W-1:0] SIZE_MAX = 20'hFFFFF;

	typedef struct {
		aabb_pkg::item_t     it;
		bit                  typed;
		aabb_pkg::step_res_t res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic [ACT_W-1:0] action;
	logic signed [POS_W-1:0] load_x;
	logic signed [POS_W-1:0] load_y;
	logic signed [POS_W-1:0] rect_left;
	logic signed [POS_W-1:0] rect_top;
	logic [SIZE_W-1:0] rect_width;
	logic [SIZE_W-1:0] rect_height;
	logic [DT_W-1:0] delta_time;
	logic signed [POS_W-1:0] vel_x;
	logic signed [POS_W-1:0] vel_y;
	logic out_valid;
	logic out_stall;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic overlapped;

	// predictor state
	longint pos_cx;
	longint pos_cy;
	longint cfg_bw;
	longint cfg_bh;

	aabb_pkg::step_res_t pending_pos[$];
	int errs;
	int burst_left;
	int stall_mode;
	int stall_left;

	aabb_push_out_tracker u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.load_x      (load_x),
		.load_y      (load_y),
		.rect_left   (rect_left),
		.rect_top    (rect_top),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.delta_time  (delta_time),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.overlapped  (overlapped)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[aabb_push_out_tracker] ERROR");
		$finish;
	end

	function automatic longint clamp_pos(input longint v);
		if (v < COORD_MIN) begin
			return COORD_MIN;
		end else if (v > COORD_MAX) begin
			return COORD_MAX;
		end
		return v;
	endfunction

	// next centre and result of one step; updates the tracked centre
	function automatic aabb_pkg::step_res_t advance_box(input aabb_pkg::item_t it);
		aabb_pkg::step_res_t r;
		longint dt, vx, vy, rw, rh, cx2, cy2, px2, py2, dx, dy, sumx, sumy, penx, peny, d;
		bit hit;
		hit = 1'b0;
		case (it.action)
			aabb_pkg::ACT_LOAD: begin
				pos_cx = $signed(it.load_x);
				pos_cy = $signed(it.load_y);
			end
			aabb_pkg::ACT_MOVE: begin
				dt = it.delta_time;
				vx = $signed(it.vel_x);
				vy = $signed(it.vel_y);
				// round to nearest, halves up, then floor by arithmetic shift
				pos_cx = clamp_pos(pos_cx + ((dt * vx + 32768) >>> 16));
				pos_cy = clamp_pos(pos_cy + ((dt * vy + 32768) >>> 16));
			end
			aabb_pkg::ACT_COLLIDE: begin
				rw = it.rect_width;
				rh = it.rect_height;
				cx2 = 2 * longint'($signed(it.rect_left)) + rw;
				cy2 = 2 * longint'($signed(it.rect_top)) + rh;
				px2 = 2 * pos_cx;
				py2 = 2 * pos_cy;
				dx = (px2 > cx2) ? px2 - cx2 : cx2 - px2;
				dy = (py2 > cy2) ? py2 - cy2 : cy2 - py2;
				sumx = cfg_bw + rw;
				sumy = cfg_bh + rh;
				if (dx < sumx && dy < sumy) begin
					hit = 1'b1;
					penx = sumx - dx;
					peny = sumy - dy;
					// doubled units: halve rounding up; tie goes to y
					if (penx < peny) begin
						d = (penx + 1) / 2;
						pos_cx = clamp_pos((px2 > cx2) ? pos_cx + d : pos_cx - d);
					end else begin
						d = (peny + 1) / 2;
						pos_cy = clamp_pos((py2 > cy2) ? pos_cy + d : pos_cy - d);
					end
				end
			end
			default: begin
			end
		endcase
		r.pos_x = pos_cx[POS_W-1:0];
		r.pos_y = pos_cy[POS_W-1:0];
		r.overlapped = hit;
		return r;
	endfunction

	function automatic aabb_pkg::item_t mk(input logic [ACT_W-1:0] a,
			input logic [POS_W-1:0] lx, input logic [POS_W-1:0] ly,
			input logic [POS_W-1:0] rl, input logic [POS_W-1:0] rt,
			input logic [SIZE_W-1:0] rw, input logic [SIZE_W-1:0] rh,
			input logic [DT_W-1:0] dt, input logic [POS_W-1:0] vx,
			input logic [POS_W-1:0] vy);
		aabb_pkg::item_t it;
		it.action = a;
		it.load_x = lx;
		it.load_y = ly;
		it.rect_left = rl;
		it.rect_top = rt;
		it.rect_width = rw;
		it.rect_height = rh;
		it.delta_time = dt;
		it.vel_x = vx;
		it.vel_y = vy;
		return it;
	endfunction

	task automatic write_reg(input int idx, input logic [SIZE_W-1:0] val);
		logic [31:0] word;
		word = $urandom;  // upper bits are don't-care
		word[SIZE_W-1:0] = val;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(idx * 4);
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_BOX_W) begin
			cfg_bw = val;
		end else if (idx == REG_BOX_H) begin
			cfg_bh = val;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// bursts of random length with random gaps between them
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100) :
				$urandom_range(1, 12);
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		burst_left--;
	endtask

	task automatic send_item(input aabb_pkg::item_t it, input bit typed,
			input aabb_pkg::step_res_t typed_res);
		aabb_pkg::step_res_t r;
		@(negedge clk);
		action <= it.action;
		load_x <= it.load_x;
		load_y <= it.load_y;
		rect_left <= it.rect_left;
		rect_top <= it.rect_top;
		rect_width <= it.rect_width;
		rect_height <= it.rect_height;
		delta_time <= it.delta_time;
		vel_x <= it.vel_x;
		vel_y <= it.vel_y;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		r = advance_box(it);
		pending_pos.push_back(typed ? typed_res : r);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pos.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [SIZE_W-1:0] bw, input logic [SIZE_W-1:0] bh,
			input int count);
		aabb_pkg::item_t it;
		int sel;
		longint span, lft, tp;
		drain();
		write_reg(REG_BOX_W, bw);
		write_reg(REG_BOX_H, bh);
		burst_left = 0;
		for (int n = 0; n < count; n++) begin
			it = mk(2'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
				24'($urandom), 20'($urandom), 20'($urandom), 16'($urandom),
				24'($urandom), 24'($urandom));
			sel = $urandom_range(0, 99);
			if (sel < 12) begin
				it.action = aabb_pkg::ACT_LOAD;
				case ($urandom_range(0, 3))
					1, 2: begin
						it.load_x = 24'(longint'($signed(16'($urandom))));
						it.load_y = 24'(longint'($signed(16'($urandom))));
					end
					3: begin
						// park the box near a corner of the coordinate range
						it.load_x = ($urandom_range(0, 1)) ?
							24'(COORD_MAX - $urandom_range(0, 16'h2000)) :
							24'(COORD_MIN + $urandom_range(0, 16'h2000));
						it.load_y = ($urandom_range(0, 1)) ?
							24'(COORD_MAX - $urandom_range(0, 16'h2000)) :
							24'(COORD_MIN + $urandom_range(0, 16'h2000));
					end
					default: begin
					end
				endcase
			end else if (sel < 40) begin
				it.action = aabb_pkg::ACT_MOVE;
				if ($urandom_range(0, 2) != 0) begin
					it.vel_x = 24'(longint'($signed(15'($urandom))));
					it.vel_y = 24'(longint'($signed(15'($urandom))));
				end
			end else if (sel < 95) begin
				it.action = aabb_pkg::ACT_COLLIDE;
				// most rectangles land around the box so that pushes happen
				if ($urandom_range(0, 6) != 0) begin
					if ($urandom_range(0, 7) != 0) begin
						it.rect_width = 20'($urandom_range(0, 16'h3000));
						it.rect_height = 20'($urandom_range(0, 16'h3000));
					end
					span = (cfg_bw + it.rect_width) / 2 + 4;
					lft = pos_cx - it.rect_width / 2 + $urandom_range(0, 2 * span) - span;
					span = (cfg_bh + it.rect_height) / 2 + 4;
					tp = pos_cy - it.rect_height / 2 + $urandom_range(0, 2 * span) - span;
					it.rect_left = 24'(lft);
					it.rect_top = 24'(tp);
				end
			end else begin
				it.action = ACT_UNUSED;
			end
			pace();
			send_item(it, 1'b0, '0);
		end
	endtask

	// receiver stall pattern: free, light, heavy and long blocking stretches
	initial begin
		out_stall = 1'b0;
		stall_mode = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(5, 60);
			end
			stall_left--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (stall_left >= 4);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		aabb_pkg::step_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pos.size() == 0) begin
				$error("result transfer with no prediction waiting: %h %h %b",
					pos_x, pos_y, overlapped);
				errs++;
			end else begin
				e = pending_pos.pop_front();
				if (pos_x !== e.pos_x) begin
					$error("pos_x: expected %h, got %h", e.pos_x, pos_x);
					errs++;
				end
				if (pos_y !== e.pos_y) begin
					$error("pos_y: expected %h, got %h", e.pos_y, pos_y);
					errs++;
				end
				if (overlapped !== e.overlapped) begin
					$error("overlapped: expected %b, got %b", e.overlapped, overlapped);
					errs++;
				end
			end
		end
	end

	initial begin : main_seq
		dir_row_t rows[$];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		action = aabb_pkg::ACT_LOAD;
		load_x = '0;
		load_y = '0;
		rect_left = '0;
		rect_top = '0;
		rect_width = '0;
		rect_height = '0;
		delta_time = '0;
		vel_x = '0;
		vel_y = '0;
		errs = 0;
		burst_left = 0;
		pos_cx = 0;
		pos_cy = 0;
		cfg_bw = 0;
		cfg_bh = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_reg(REG_BOX_W, 20'h01000);
		write_reg(REG_BOX_H, 20'h00800);

		// zero time leaves the reset centre alone
		rows.push_back('{mk(aabb_pkg::ACT_MOVE, 0, 0, 0, 0, 0, 0, 16'h0000, 24'h7FFFFF,
			24'h800000), 1'b1, '{24'h000000, 24'h000000, 1'b0}});
		rows.push_back('{mk(aabb_pkg::ACT_LOAD, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 0, 0, 0, 0, 0),
			1'b1, '{24'h7FFFFF, 24'h7FFFFF, 1'b0}});
		rows.push_back('{mk(aabb_pkg::ACT_MOVE, 0, 0, 0, 0, 0, 0, 16'hFFFF, 24'h7FFFFF,
			24'h7FFFFF), 1'b1, '{24'h7FFFFF, 24'h7FFFFF, 1'b0}});
		rows.push_back('{mk(aabb_pkg::ACT_LOAD, 24'h800000, 24'h800000, 0, 0, 0, 0, 0, 0, 0),
			1'b1, '{24'h800000, 24'h800000, 1'b0}});
		rows.push_back('{mk(aabb_pkg::ACT_MOVE, 0, 0, 0, 0, 0, 0, 16'hFFFF, 24'h800000,
			24'h800000), 1'b1, '{24'h800000, 24'h800000, 1'b0}});
		// unused action code changes nothing
		rows.push_back('{mk(ACT_UNUSED, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			SIZE_MAX, SIZE_MAX, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF),
			1'b1, '{24'h800000, 24'h800000, 1'b0}});
		rows.push_back('{mk(aabb_pkg::ACT_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b1, '{24'h000000, 24'h000000, 1'b0}});
		// obstacle far away
		rows.push_back('{mk(aabb_pkg::ACT_COLLIDE, 0, 0, 24'h100000, 0, 20'h100, 20'h100,
			0, 0, 0), 1'b1, '{24'h000000, 24'h000000, 1'b0}});
		// centre on the obstacle centre goes negative
		rows.push_back('{mk(aabb_pkg::ACT_COLLIDE, 0, 0, -24'sd1024, -24'sd1024, 20'h800,
			20'h800, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(aabb_pkg::ACT_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b1, '{24'h000000, 24'h000000, 1'b0}});
		// equal penetration on both axes
		rows.push_back('{mk(aabb_pkg::ACT_COLLIDE, 0, 0, -24'sd1024, -24'sd2048, 20'h800,
			20'h1000, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(aabb_pkg::ACT_LOAD, 24'h000100, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b1, '{24'h000100, 24'h000000, 1'b0}});
		rows.push_back('{mk(aabb_pkg::ACT_COLLIDE, 0, 0, -24'sd1024, -24'sd8192, 20'h800,
			20'h4000, 0, 0, 0), 1'b0, '0});
		// odd width: obstacle centre on a half lsb
		rows.push_back('{mk(aabb_pkg::ACT_COLLIDE, 0, 0, -24'sd1024, -24'sd8192, 20'h801,
			20'h4000, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(aabb_pkg::ACT_LOAD, 24'h7FFF00, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b1, '{24'h7FFF00, 24'h000000, 1'b0}});
		// push past the top of the range clamps
		rows.push_back('{mk(aabb_pkg::ACT_COLLIDE, 0, 0, 24'h7FFE00, -24'sd8192, 20'h100,
			20'h4000, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(aabb_pkg::ACT_COLLIDE, 0, 0, 24'h7FFFFF, 24'h7FFFFF, SIZE_MAX,
			SIZE_MAX, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(aabb_pkg::ACT_COLLIDE, 0, 0, 24'h800000, 24'h800000, SIZE_MAX,
			SIZE_MAX, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk(aabb_pkg::ACT_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b1, '{24'h000000, 24'h000000, 1'b0}});
		// rounding of the velocity step at the half
		rows.push_back('{mk(aabb_pkg::ACT_MOVE, 0, 0, 0, 0, 0, 0, 16'h0001, 24'h008000,
			-24'sd32768), 1'b0, '0});
		rows.push_back('{mk(aabb_pkg::ACT_MOVE, 0, 0, 0, 0, 0, 0, 16'h0001, -24'sd32769,
			24'h007FFF), 1'b0, '0});
		rows.push_back('{mk(aabb_pkg::ACT_MOVE, 0, 0, 0, 0, 0, 0, 16'h8000, 24'sd3,
			-24'sd3), 1'b0, '0});
		rows.push_back('{mk(aabb_pkg::ACT_LOAD, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0, 0, 0, 0),
			1'b1, '{24'h7FFFFF, 24'h800000, 1'b0}});

		foreach (rows[i]) begin
			pace();
			send_item(rows[i].it, rows[i].typed, rows[i].res);
		end

		run_phase(20'h00000, 20'h00000, 200);
		run_phase(SIZE_MAX, SIZE_MAX, 200);
		run_phase(20'h01000, 20'h00800, 200);
		run_phase(20'h00001, SIZE_MAX, 200);
		run_phase(20'($urandom), 20'($urandom), 200);
		run_phase(20'($urandom_range(0, 16'h4000)), 20'($urandom_range(0, 16'h4000)), 200);
		run_phase(SIZE_MAX, 20'h00000, 200);

		drain();
		repeat (20) @(posedge clk);
		if (errs == 0 && pending_pos.size() == 0) begin
			$display("[aabb_push_out_tracker] OK");
		end else begin
			$display("[aabb_push_out_tracker] ERROR");
		end
		$finish;
	end

endmodule
